[src/fijc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fijc_pkg: shared types, constants and functions of the jank counter
// Standard frame time table, decimal digit helpers, payload and view structs.
// ----------------------------------------------------------------------------
package fijc_pkg;

   localparam int FPS_W       = 8;
   localparam int PERIOD_W    = 30;
   localparam int STAMP_W     = 64;
   localparam int IV_W        = 32;
   localparam int COUNT_W     = 32;
   localparam int STD_TIME_W  = 25;
   localparam int STD_IDX_W   = 3;
   localparam int STD_COUNT   = 6;
   localparam int LEN_W       = 4;
   localparam int DIGIT_W     = 4;
   localparam int PREFIX_W    = 7;
   localparam int BOUND_W     = 40;
   localparam int SEEN_W      = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 30;

   localparam logic [SEEN_W-1:0]   SEEN_MAX  = 3'd4;
   localparam logic [SEEN_W-1:0]   FEW_LIMIT = 3'd3;
   localparam logic [LEN_W-1:0]    SHORT_LEAD_MAX = 4'd7;
   localparam logic [FPS_W-1:0]    FPS_RESET    = 8'd60;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = '0;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MEASURED_FPS   = 1'b0,
      CSR_DISPLAY_PERIOD = 1'b1
   } csr_index_type;

   // windows: reference value at candidate digit count
   localparam int WIN_COUNT     = 4;
   localparam int WIN_HIGH_AT_H = 0;
   localparam int WIN_LOW_AT_H  = 1;
   localparam int WIN_HIGH_AT_L = 2;
   localparam int WIN_LOW_AT_L  = 3;

   typedef struct packed {
      logic [STAMP_W-1:0] vsync_stamp_ns;
      logic               is_last_stamp;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0]        over_count;
      logic [COUNT_W-1:0]        within_count;
      logic signed [FPS_W-1:0]   missed_frames;
      logic [STD_TIME_W-1:0]     standard_period_ns;
      logic                      too_few_stamps;
   } rsp_payload_type;

   typedef struct packed {
      logic               ok;
      logic [BOUND_W-1:0] lo;
      logic [BOUND_W-1:0] hi;
   } window_type;

   typedef struct packed {
      window_type [WIN_COUNT-1:0] win;
      logic [LEN_W-1:0]           high_len;
      logic [LEN_W-1:0]           low_len;
      logic                       snap_en;
      logic [STD_TIME_W-1:0]      std_time;
      logic [FPS_W-1:0]           missed;
   } cfg_view_type;

   function automatic logic [FPS_W-1:0] std_fps(input logic [STD_IDX_W-1:0] idx);
      case (idx)
         3'd0:    return 8'd30;
         3'd1:    return 8'd45;
         3'd2:    return 8'd60;
         3'd3:    return 8'd90;
         3'd4:    return 8'd120;
         default: return 8'd144;
      endcase
   endfunction

   function automatic logic [STD_TIME_W-1:0] std_time(input logic [STD_IDX_W-1:0] idx);
      case (idx)
         3'd0:    return 25'd33333333;
         3'd1:    return 25'd22222222;
         3'd2:    return 25'd16666666;
         3'd3:    return 25'd11111111;
         3'd4:    return 25'd8333333;
         default: return 25'd6944444;
      endcase
   endfunction

   // lowest standard rate not below fps - 3, at most 144
   function automatic logic [STD_IDX_W-1:0] pick_standard(input logic [FPS_W-1:0] fps);
      logic [STD_IDX_W-1:0] idx;
      logic                 found;
      idx   = STD_IDX_W'(STD_COUNT - 1);
      found = 1'b0;
      for (int k = 0; k < STD_COUNT - 1; k++) begin
         if (!found && std_fps(STD_IDX_W'(k)) < fps &&
             ({1'b0, std_fps(STD_IDX_W'(k + 1))} + 9'd4) > {1'b0, fps}) begin
            idx   = STD_IDX_W'(k + 1);
            found = 1'b1;
         end
      end
      if ({1'b0, fps} <= {1'b0, std_fps(3'd0)} + 9'd3) begin
         idx = 3'd0;
      end else if (fps >= std_fps(STD_IDX_W'(STD_COUNT - 1))) begin
         idx = STD_IDX_W'(STD_COUNT - 1);
      end
      return idx;
   endfunction

   function automatic logic [IV_W-1:0] pow10(input logic [LEN_W-1:0] e);
      case (e)
         4'd0:    return 32'd1;
         4'd1:    return 32'd10;
         4'd2:    return 32'd100;
         4'd3:    return 32'd1000;
         4'd4:    return 32'd10000;
         4'd5:    return 32'd100000;
         4'd6:    return 32'd1000000;
         4'd7:    return 32'd10000000;
         4'd8:    return 32'd100000000;
         4'd9:    return 32'd1000000000;
         default: return 32'd0;
      endcase
   endfunction

   // decimal digit count, zero counts as one digit
   function automatic logic [LEN_W-1:0] digit_len(input logic [IV_W-1:0] v);
      logic [LEN_W-1:0] n;
      n = 4'd1;
      for (int k = 1; k <= 9; k++) begin
         if (v >= pow10(LEN_W'(k))) n = n + 4'd1;
      end
      return n;
   endfunction

   // leading digit of a value with the given digit count
   function automatic logic [DIGIT_W-1:0] lead_digit(input logic [IV_W-1:0] v,
                                                     input logic [LEN_W-1:0] len);
      logic [DIGIT_W-1:0] cnt;
      logic [BOUND_W-1:0] unit;
      cnt  = '0;
      unit = BOUND_W'(pow10(len - 4'd1));
      for (int d = 1; d <= 9; d++) begin
         if (BOUND_W'(v) >= BOUND_W'(d) * unit) cnt = cnt + 4'd1;
      end
      return cnt;
   endfunction

   // value range of an interval that shares the reference prefix
   function automatic window_type make_window(input logic [DIGIT_W-1:0] lead,
                                              input logic [DIGIT_W-1:0] second,
                                              input logic [LEN_W-1:0]   ref_len,
                                              input logic [LEN_W-1:0]   cand_len);
      window_type       w;
      logic [PREFIX_W-1:0] prefix;
      logic [LEN_W-1:0]    e;
      if (cand_len <= SHORT_LEAD_MAX) begin
         prefix = PREFIX_W'(lead);
         e      = cand_len - 4'd1;
         w.ok   = 1'b1;
      end else begin
         prefix = PREFIX_W'(lead) * 7'd10 + PREFIX_W'(second);
         e      = cand_len - 4'd2;
         w.ok   = (ref_len >= 4'd2);
      end
      w.lo = BOUND_W'(prefix) * BOUND_W'(pow10(e));
      w.hi = (BOUND_W'(prefix) + 40'd1) * BOUND_W'(pow10(e));
      return w;
   endfunction

endpackage
`default_nettype wire

[src/fijc_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fijc_stream_if: valid/ready channel
// Carries one payload per transfer; source drives valid and payload.
// ----------------------------------------------------------------------------
interface fijc_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[src/fijc_cfg_derive.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fijc_cfg_derive: register-derived comparison windows
// Four-stage pipeline from the settings to the standard time, the snap
// references' digit counts and the interval windows used for snapping.
// ----------------------------------------------------------------------------
module fijc_cfg_derive
   import fijc_pkg::*;
(
   input  logic                clock,
   input  logic [FPS_W-1:0]    fps,
   input  logic [PERIOD_W-1:0] period,
   output cfg_view_type        view
);

   logic [STD_IDX_W-1:0]  std_idx;

   logic [STD_TIME_W-1:0] std_time_1_ff, std_time_1_in;
   logic [FPS_W-1:0]      missed_1_ff, missed_1_in;
   logic [IV_W-1:0]       high_1_ff, high_1_in;
   logic [IV_W-1:0]       low_1_ff, low_1_in;
   logic                  snap_1_ff, snap_1_in;

   logic [STD_TIME_W-1:0] std_time_2_ff;
   logic [FPS_W-1:0]      missed_2_ff;
   logic [IV_W-1:0]       high_2_ff, low_2_ff;
   logic                  snap_2_ff;
   logic [LEN_W-1:0]      high_len_2_ff, high_len_2_in;
   logic [LEN_W-1:0]      low_len_2_ff, low_len_2_in;
   logic [DIGIT_W-1:0]    high_lead_2_ff, high_lead_2_in;
   logic [DIGIT_W-1:0]    low_lead_2_ff, low_lead_2_in;

   logic [STD_TIME_W-1:0] std_time_3_ff;
   logic [FPS_W-1:0]      missed_3_ff;
   logic                  snap_3_ff;
   logic [LEN_W-1:0]      high_len_3_ff, low_len_3_ff;
   logic [DIGIT_W-1:0]    high_lead_3_ff, low_lead_3_ff;
   logic [DIGIT_W-1:0]    high_second_3_ff, high_second_3_in;
   logic [DIGIT_W-1:0]    low_second_3_ff, low_second_3_in;
   logic [IV_W-1:0]       high_rem, low_rem;

   cfg_view_type          view_ff, view_in;

   // stage 1: standard time and references
   always_comb begin
      std_idx       = pick_standard(fps);
      std_time_1_in = std_time(std_idx);
      missed_1_in   = std_fps(std_idx) - fps - 8'd2;
      high_1_in     = IV_W'({std_time_1_in, 1'b0}) - IV_W'(period);
      low_1_in      = IV_W'(period);
      snap_1_in     = PERIOD_W'(std_time_1_in) > period;
   end

   // stage 2: digit counts and leading digits
   always_comb begin
      high_len_2_in  = digit_len(high_1_ff);
      low_len_2_in   = digit_len(low_1_ff);
      high_lead_2_in = lead_digit(high_1_ff, high_len_2_in);
      low_lead_2_in  = lead_digit(low_1_ff, low_len_2_in);
   end

   // stage 3: second digits
   always_comb begin
      high_rem = high_2_ff - IV_W'(high_lead_2_ff) * pow10(high_len_2_ff - 4'd1);
      low_rem  = low_2_ff - IV_W'(low_lead_2_ff) * pow10(low_len_2_ff - 4'd1);
      high_second_3_in = lead_digit(high_rem, high_len_2_ff - 4'd1);
      low_second_3_in  = lead_digit(low_rem, low_len_2_ff - 4'd1);
   end

   // stage 4: windows
   always_comb begin
      view_in.win[WIN_HIGH_AT_H] = make_window(high_lead_3_ff, high_second_3_ff,
                                               high_len_3_ff, high_len_3_ff);
      view_in.win[WIN_LOW_AT_H]  = make_window(low_lead_3_ff, low_second_3_ff,
                                               low_len_3_ff, high_len_3_ff);
      view_in.win[WIN_HIGH_AT_L] = make_window(high_lead_3_ff, high_second_3_ff,
                                               high_len_3_ff, low_len_3_ff);
      view_in.win[WIN_LOW_AT_L]  = make_window(low_lead_3_ff, low_second_3_ff,
                                               low_len_3_ff, low_len_3_ff);
      view_in.high_len = high_len_3_ff;
      view_in.low_len  = low_len_3_ff;
      view_in.snap_en  = snap_3_ff;
      view_in.std_time = std_time_3_ff;
      view_in.missed   = missed_3_ff;
   end

   always_ff @(posedge clock) begin
      std_time_1_ff    <= std_time_1_in;
      missed_1_ff      <= missed_1_in;
      high_1_ff        <= high_1_in;
      low_1_ff         <= low_1_in;
      snap_1_ff        <= snap_1_in;

      std_time_2_ff    <= std_time_1_ff;
      missed_2_ff      <= missed_1_ff;
      high_2_ff        <= high_1_ff;
      low_2_ff         <= low_1_ff;
      snap_2_ff        <= snap_1_ff;
      high_len_2_ff    <= high_len_2_in;
      low_len_2_ff     <= low_len_2_in;
      high_lead_2_ff   <= high_lead_2_in;
      low_lead_2_ff    <= low_lead_2_in;

      std_time_3_ff    <= std_time_2_ff;
      missed_3_ff      <= missed_2_ff;
      snap_3_ff        <= snap_2_ff;
      high_len_3_ff    <= high_len_2_ff;
      low_len_3_ff     <= low_len_2_ff;
      high_lead_3_ff   <= high_lead_2_ff;
      low_lead_3_ff    <= low_lead_2_ff;
      high_second_3_ff <= high_second_3_in;
      low_second_3_ff  <= low_second_3_in;

      view_ff          <= view_in;
   end

   assign view = view_ff;

endmodule
`default_nettype wire

[src/frame_interval_jank_counter_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_interval_jank_counter_top: vsync interval jank counter
// Counts batch intervals over / within the standard frame time, with
// snapping of vsync-quantised intervals, and reports on the last stamp.
//
//   channel  role  transfer when            payload
//   req_bus  in    valid & ready            vsync_stamp_ns, is_last_stamp
//   rsp_bus  out   valid & ready            counts, missed fps, std time, flag
//   csr_*    in    csr_write_en             register index, write data
//
// one stamp per cycle while ready is high; a result is registered after its last
// stamp leaves stage 4; a register write, then hold_ff, hold ready low while the
// four-stage window pipeline settles; ready is also low in the cycle after reset
// a waiting result stalls the pipe only when the next last stamp reaches it
// ----------------------------------------------------------------------------
module frame_interval_jank_counter_top
   import fijc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   fijc_stream_if.sink            req_bus,
   fijc_stream_if.source          rsp_bus,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [FPS_W-1:0]    fps_ff, fps_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                hold_ff, hold_in;
   cfg_view_type        view;

   logic advance, take;

   logic                s1_valid_ff, s1_valid_in;
   logic [STAMP_W-1:0]  s1_stamp_ff, s1_stamp_in;
   logic                s1_last_ff, s1_last_in;

   logic [STAMP_W-1:0]  prev_stamp_ff, prev_stamp_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;

   logic                s2_valid_ff, s2_valid_in;
   logic                s2_last_ff, s2_last_in;
   logic                s2_keep_ff, s2_keep_in;
   logic                s2_few_ff, s2_few_in;
   logic [IV_W-1:0]     s2_iv_ff, s2_iv_in;

   logic                s3_valid_ff, s3_valid_in;
   logic                s3_last_ff, s3_last_in;
   logic                s3_keep_ff, s3_keep_in;
   logic                s3_few_ff, s3_few_in;
   logic [IV_W-1:0]     s3_iv_ff, s3_iv_in;
   logic [LEN_W-1:0]    s3_len_ff, s3_len_in;

   logic [WIN_COUNT-1:0] in_win;
   logic                 snap_hit, beyond;

   logic                s4_valid_ff, s4_valid_in;
   logic                s4_last_ff, s4_last_in;
   logic                s4_few_ff, s4_few_in;
   logic                s4_over_ff, s4_over_in;
   logic                s4_within_ff, s4_within_in;

   logic [COUNT_W-1:0]  over_tally_ff, over_tally_in;
   logic [COUNT_W-1:0]  within_tally_ff, within_tally_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   // register port
   always_comb begin
      fps_in    = fps_ff;
      period_in = period_ff;
      hold_in   = 1'b0;
      if (csr_write_en) begin
         hold_in = 1'b1;
         unique case (csr_index_type'(csr_index))
            CSR_MEASURED_FPS:   fps_in    = csr_write_data[FPS_W-1:0];
            CSR_DISPLAY_PERIOD: period_in = csr_write_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   fijc_cfg_derive u_cfg_derive (
      .clock  (clock),
      .fps    (fps_ff),
      .period (period_ff),
      .view   (view)
   );

   assign advance = !(s4_valid_ff && s4_last_ff && rsp_valid_ff && !rsp_bus.ready);
   assign req_bus.ready = advance && !hold_ff && !csr_write_en;
   assign take = req_bus.valid && req_bus.ready;

   // stage 1: input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_stamp_in = s1_stamp_ff;
      s1_last_in  = s1_last_ff;
      if (advance) begin
         s1_valid_in = take;
         s1_stamp_in = req_bus.payload.vsync_stamp_ns;
         s1_last_in  = req_bus.payload.is_last_stamp;
      end
   end

   // stage 2: interval and batch bookkeeping
   always_comb begin
      prev_stamp_in = prev_stamp_ff;
      seen_in       = seen_ff;
      s2_valid_in   = s2_valid_ff;
      s2_last_in    = s2_last_ff;
      s2_keep_in    = s2_keep_ff;
      s2_few_in     = s2_few_ff;
      s2_iv_in      = s2_iv_ff;
      if (advance) begin
         s2_valid_in = s1_valid_ff;
         s2_last_in  = s1_last_ff;
         s2_keep_in  = s1_valid_ff && !s1_last_ff && (seen_ff != '0) &&
                       (s1_stamp_ff > prev_stamp_ff);
         s2_few_in   = seen_ff < FEW_LIMIT;
         s2_iv_in    = s1_stamp_ff[IV_W-1:0] - prev_stamp_ff[IV_W-1:0];
         if (s1_valid_ff) begin
            if (s1_last_ff) begin
               prev_stamp_in = '0;
               seen_in       = '0;
            end else begin
               prev_stamp_in = s1_stamp_ff;
               seen_in       = (seen_ff == SEEN_MAX) ? SEEN_MAX : seen_ff + 3'd1;
            end
         end
      end
   end

   // stage 3: digit count of the interval
   always_comb begin
      s3_valid_in = s3_valid_ff;
      s3_last_in  = s3_last_ff;
      s3_keep_in  = s3_keep_ff;
      s3_few_in   = s3_few_ff;
      s3_iv_in    = s3_iv_ff;
      s3_len_in   = s3_len_ff;
      if (advance) begin
         s3_valid_in = s2_valid_ff;
         s3_last_in  = s2_last_ff;
         s3_keep_in  = s2_keep_ff;
         s3_few_in   = s2_few_ff;
         s3_iv_in    = s2_iv_ff;
         s3_len_in   = digit_len(s2_iv_ff);
      end
   end

   // stage 4: snap and classify
   always_comb begin
      for (int w = 0; w < WIN_COUNT; w++) begin
         in_win[w] = view.win[w].ok &&
                     (BOUND_W'(s3_iv_ff) >= view.win[w].lo) &&
                     (BOUND_W'(s3_iv_ff) <  view.win[w].hi);
      end
      snap_hit = view.snap_en &&
                 ((s3_len_ff == view.high_len &&
                   (in_win[WIN_HIGH_AT_H] || in_win[WIN_LOW_AT_H])) ||
                  (s3_len_ff == view.low_len &&
                   (in_win[WIN_HIGH_AT_L] || in_win[WIN_LOW_AT_L])));
      beyond = !snap_hit && (s3_iv_ff > IV_W'(view.std_time));

      s4_valid_in  = s4_valid_ff;
      s4_last_in   = s4_last_ff;
      s4_few_in    = s4_few_ff;
      s4_over_in   = s4_over_ff;
      s4_within_in = s4_within_ff;
      if (advance) begin
         s4_valid_in  = s3_valid_ff;
         s4_last_in   = s3_last_ff;
         s4_few_in    = s3_few_ff;
         s4_over_in   = s3_keep_ff && beyond;
         s4_within_in = s3_keep_ff && !beyond;
      end
   end

   // tallies and result register
   always_comb begin
      over_tally_in   = over_tally_ff;
      within_tally_in = within_tally_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_payload_in  = rsp_payload_ff;
      if (rsp_bus.ready) rsp_valid_in = 1'b0;
      if (advance && s4_valid_ff) begin
         if (s4_last_ff) begin
            rsp_valid_in                      = 1'b1;
            rsp_payload_in.over_count         = s4_few_ff ? '0 : over_tally_ff;
            rsp_payload_in.within_count       = s4_few_ff ? '0 : within_tally_ff;
            rsp_payload_in.missed_frames      = view.missed;
            rsp_payload_in.standard_period_ns = view.std_time;
            rsp_payload_in.too_few_stamps     = s4_few_ff;
            over_tally_in                     = '0;
            within_tally_in                   = '0;
         end else begin
            if (s4_over_ff && over_tally_ff != COUNT_MAX) begin
               over_tally_in = over_tally_ff + 32'd1;
            end
            if (s4_within_ff && within_tally_ff != COUNT_MAX) begin
               within_tally_in = within_tally_ff + 32'd1;
            end
         end
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fps_ff          <= FPS_RESET;
         period_ff       <= PERIOD_RESET;
         hold_ff         <= 1'b1;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         s4_valid_ff     <= 1'b0;
         prev_stamp_ff   <= '0;
         seen_ff         <= '0;
         over_tally_ff   <= '0;
         within_tally_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         fps_ff          <= fps_in;
         period_ff       <= period_in;
         hold_ff         <= hold_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         s3_valid_ff     <= s3_valid_in;
         s4_valid_ff     <= s4_valid_in;
         prev_stamp_ff   <= prev_stamp_in;
         seen_ff         <= seen_in;
         over_tally_ff   <= over_tally_in;
         within_tally_ff <= within_tally_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_stamp_ff    <= s1_stamp_in;
      s1_last_ff     <= s1_last_in;
      s2_last_ff     <= s2_last_in;
      s2_keep_ff     <= s2_keep_in;
      s2_few_ff      <= s2_few_in;
      s2_iv_ff       <= s2_iv_in;
      s3_last_ff     <= s3_last_in;
      s3_keep_ff     <= s3_keep_in;
      s3_few_ff      <= s3_few_in;
      s3_iv_ff       <= s3_iv_in;
      s3_len_ff      <= s3_len_in;
      s4_last_ff     <= s4_last_in;
      s4_few_ff      <= s4_few_in;
      s4_over_ff     <= s4_over_in;
      s4_within_ff   <= s4_within_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // no stamp taken right after a register write
   a_settle_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> !(req_bus.valid && req_bus.ready))
      else $error("stamp transfer while window pipeline settles");

   // tallies clear once the last stamp leaves the pipe
   a_tally_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && s4_valid_ff && s4_last_ff) |=>
         (over_tally_ff == '0 && within_tally_ff == '0 && seen_ff <= SEEN_MAX))
      else $error("tallies not cleared after batch result");

   // one interval never counts both ways
   a_one_class: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> !(s4_over_ff && s4_within_ff))
      else $error("interval counted as both over and within");

   // short batch reports zero counts
   a_few_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.too_few_stamps) |->
         (rsp_payload_ff.over_count == '0 && rsp_payload_ff.within_count == '0))
      else $error("short batch with non-zero counts");

endmodule
`default_nettype wire
